// ===== rtl/core/lapet_pkg.sv =====
// Shared types, constants and helpers of the Laplacian edge detector.
`timescale 1ns / 1ps

package lapet_pkg;

  // Frame geometry limits and counter widths.
  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 2048;
  localparam int unsigned PosW      = 11;
  localparam int unsigned SizeW     = 12;
  localparam int unsigned AddrW     = $clog2(MaxWidth);

  // Depth of the queue between front and back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Fixed point luma coefficients, scaled by 2^16, plus rounding offset.
  localparam logic [23:0] CoefR     = 24'd19595;
  localparam logic [23:0] CoefG     = 24'd38470;
  localparam logic [23:0] CoefB     = 24'd7471;
  localparam logic [23:0] LumaRound = 24'd32768;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgThresh = 2'd2
  } cfg_idx_e;

  // One word handed from the front to the back.
  typedef struct packed {
    logic [7:0]      up;
    logic [7:0]      mid;
    logic [7:0]      luma;
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
    logic            last_col;
    logic            last_row;
  } item_t;

  // Clamp a programmed size into 1..limit.
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] v,
                                                input logic [SizeW-1:0] lim);
    logic [SizeW-1:0] res;
    if (v == '0) begin
      res = SizeW'(1);
    end else if (v > lim) begin
      res = lim;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/lapet_front.sv =====
// Front part: pixel acceptance, luma conversion, line buffers and raster position.
`timescale 1ns / 1ps

module lapet_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         red_i,
  input  logic [7:0]                         green_i,
  input  logic [7:0]                         blue_i,
  input  logic [lapet_pkg::SizeW-1:0]        frame_width_i,
  input  logic [lapet_pkg::SizeW-1:0]        frame_height_i,
  input  logic [lapet_pkg::QCntW-1:0]        q_count_i,
  output logic                               push_o,
  output lapet_pkg::item_t                   push_item_o
);

  localparam logic [lapet_pkg::SizeW-1:0] WLim = lapet_pkg::SizeW'(lapet_pkg::MaxWidth);
  localparam logic [lapet_pkg::SizeW-1:0] HLim = lapet_pkg::SizeW'(lapet_pkg::MaxHeight);

  logic                          accept;
  logic [lapet_pkg::QCntW:0]     used;
  logic [lapet_pkg::SizeW-1:0]   w_eff, h_eff;
  logic                          last_col, last_row;
  logic [lapet_pkg::PosW-1:0]    col_q, col_d, row_q, row_d;

  logic                          valid_a_q;
  logic [23:0]                   prod_r_q, prod_g_q, prod_b_q;
  logic [lapet_pkg::PosW-1:0]    col_a_q, row_a_q;
  logic                          lc_a_q, lr_a_q;
  logic [15:0]                   line_rd_q;
  logic                          fwd_q;
  logic [15:0]                   fwd_data_q;

  logic [23:0]                   luma_sum;
  logic [7:0]                    luma_a, up_a, mid_a;
  logic [15:0]                   line_wdata;

  logic [15:0] line_mem [lapet_pkg::MaxWidth];

  // Room is reserved in the queue for the word still in flight.
  assign used       = {1'b0, q_count_i} + {{lapet_pkg::QCntW{1'b0}}, valid_a_q};
  assign in_ready_o = used < (lapet_pkg::QCntW + 1)'(lapet_pkg::QDepth - 1);
  assign accept     = in_valid_i && in_ready_o;

  // Position of the incoming pixel within the frame.
  assign w_eff    = lapet_pkg::eff_size(frame_width_i, WLim);
  assign h_eff    = lapet_pkg::eff_size(frame_height_i, HLim);
  assign last_col = ({1'b0, col_q} + lapet_pkg::SizeW'(1)) >= w_eff;
  assign last_row = ({1'b0, row_q} + lapet_pkg::SizeW'(1)) >= h_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + lapet_pkg::PosW'(1);
      end else begin
        col_d = col_q + lapet_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      valid_a_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      valid_a_q <= accept;
      if (accept) begin
        fwd_q <= valid_a_q && (col_a_q == col_q);
      end
    end
  end

  // Luma products and position are captured with the pixel.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_r_q   <= lapet_pkg::CoefR * {16'b0, red_i};
      prod_g_q   <= lapet_pkg::CoefG * {16'b0, green_i};
      prod_b_q   <= lapet_pkg::CoefB * {16'b0, blue_i};
      col_a_q    <= col_q;
      row_a_q    <= row_q;
      lc_a_q     <= last_col;
      lr_a_q     <= last_row;
      fwd_data_q <= line_wdata;
    end
  end

  // Sum and round the products; pick the line data, bypassing a write of the same column.
  assign luma_sum   = prod_r_q + prod_g_q + prod_b_q + lapet_pkg::LumaRound;
  assign luma_a     = luma_sum[23:16];
  assign up_a       = fwd_q ? fwd_data_q[15:8] : line_rd_q[15:8];
  assign mid_a      = fwd_q ? fwd_data_q[7:0]  : line_rd_q[7:0];
  assign line_wdata = {mid_a, luma_a};

  // Line buffer: upper byte holds row r-2, lower byte row r-1 of each column.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_rd_q <= line_mem[col_q[lapet_pkg::AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_a_q) begin
      line_mem[col_a_q[lapet_pkg::AddrW-1:0]] <= line_wdata;
    end
  end

  // Word handed to the queue.
  assign push_o                = valid_a_q;
  assign push_item_o.up        = up_a;
  assign push_item_o.mid       = mid_a;
  assign push_item_o.luma      = luma_a;
  assign push_item_o.col       = col_a_q;
  assign push_item_o.row       = row_a_q;
  assign push_item_o.last_col  = lc_a_q;
  assign push_item_o.last_row  = lr_a_q;

endmodule

// ===== rtl/core/lapet_fifo.sv =====
// Short queue of words between the front and the back.
`timescale 1ns / 1ps

module lapet_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  lapet_pkg::item_t            push_item_i,
  input  logic                        pop_i,
  output lapet_pkg::item_t            pop_item_o,
  output logic                        empty_o,
  output logic [lapet_pkg::QCntW-1:0] count_o
);

  lapet_pkg::item_t              q_mem [lapet_pkg::QDepth];
  logic [lapet_pkg::QPtrW-1:0]   wptr_q, rptr_q;
  logic [lapet_pkg::QCntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + lapet_pkg::QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - lapet_pkg::QCntW'(1);
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= wptr_q + lapet_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + lapet_pkg::QPtrW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wptr_q] <= push_item_i;
    end
  end

  assign pop_item_o = q_mem[rptr_q];
  assign empty_o    = (cnt_q == '0);
  assign count_o    = cnt_q;

  // The front reserves room, so the queue never overflows or underflows.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < lapet_pkg::QCntW'(lapet_pkg::QDepth)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("queue pop while empty");

endmodule

// ===== rtl/core/lapet_back.sv =====
// Back part: 3x3 window, Laplacian kernel, threshold and result sequencing.
`timescale 1ns / 1ps

module lapet_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_empty_i,
  input  lapet_pkg::item_t         q_item_i,
  output logic                     q_pop_o,
  input  logic [10:0]              edge_threshold_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     is_edge_o,
  output logic [lapet_pkg::PosW-1:0] out_col_o,
  output logic [lapet_pkg::PosW-1:0] out_row_o,
  output logic                     last_of_run_o,
  output logic                     frame_done_o
);

  // Window, indexed [column slot][row slot]; slot 2 is the newest.
  logic [2:0][2:0][7:0]        win_q;

  // Current word being turned into results.
  logic                        job_valid_q;
  logic [1:0]                  idx_q;
  logic [2:0]                  n_q;
  logic                        nc2_q;
  logic                        cprev_q, rprev_q, c_one_q, r_one_q, fend_q;
  logic [lapet_pkg::PosW-1:0]  col_q, row_q;

  logic                        out_space, emit, is_last, job_done, pop;
  logic [1:0]                  nr, nc;
  logic                        a_sel, b_sel, col_prev, row_prev;
  logic [1:0]                  cm, cl, cr, rm, rt, rb;
  logic [7:0]                  v_ctr, v_top, v_bot, v_lft, v_rgt;
  logic signed [11:0]          lap_sum;
  logic                        edge_bit;

  function automatic logic [7:0] win_pick(input logic [2:0][2:0][7:0] w,
                                          input logic [1:0] cs,
                                          input logic [1:0] rs);
    logic [2:0][7:0] colv;
    logic [7:0]      res;
    case (cs)
      2'd0:    colv = w[0];
      2'd1:    colv = w[1];
      default: colv = w[2];
    endcase
    case (rs)
      2'd0:    res = colv[0];
      2'd1:    res = colv[1];
      default: res = colv[2];
    endcase
    return res;
  endfunction

  // Handshake between the job, the output register and the queue.
  assign out_space = !out_valid_o || out_ready_i;
  assign is_last   = ({1'b0, idx_q} + 3'd1) == n_q;
  assign emit      = job_valid_q && (n_q != 3'd0) && out_space;
  assign job_done  = job_valid_q && ((n_q == 3'd0) || (emit && is_last));
  assign pop       = !q_empty_i && (!job_valid_q || job_done);
  assign q_pop_o   = pop;

  // Result count of the incoming word: rows times columns.
  assign nr = {1'b0, q_item_i.row != '0} + {1'b0, q_item_i.last_row};
  assign nc = {1'b0, q_item_i.col != '0} + {1'b0, q_item_i.last_col};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      win_q       <= '0;
    end else begin
      if (pop) begin
        job_valid_q <= 1'b1;
        idx_q       <= '0;
        win_q[0]    <= win_q[1];
        win_q[1]    <= win_q[2];
        win_q[2]    <= {q_item_i.luma, q_item_i.mid, q_item_i.up};
      end else if (job_done) begin
        job_valid_q <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      n_q     <= 3'({1'b0, nr} * {1'b0, nc});
      nc2_q   <= (nc == 2'd2);
      cprev_q <= (q_item_i.col != '0);
      rprev_q <= (q_item_i.row != '0);
      c_one_q <= (q_item_i.col == lapet_pkg::PosW'(1));
      r_one_q <= (q_item_i.row == lapet_pkg::PosW'(1));
      fend_q  <= q_item_i.last_col && q_item_i.last_row;
      col_q   <= q_item_i.col;
      row_q   <= q_item_i.row;
    end
  end

  // Which row and column this result covers, ordered by row then column.
  assign a_sel    = nc2_q ? idx_q[1] : idx_q[0];
  assign b_sel    = nc2_q ? idx_q[0] : 1'b0;
  assign col_prev = !b_sel && cprev_q;
  assign row_prev = !a_sel && rprev_q;

  // Window slots with clamp-to-edge borders.
  assign cm = col_prev ? 2'd1 : 2'd2;
  assign cl = col_prev ? (c_one_q ? 2'd1 : 2'd0) : (cprev_q ? 2'd1 : 2'd2);
  assign cr = 2'd2;
  assign rm = row_prev ? 2'd1 : 2'd2;
  assign rt = row_prev ? (r_one_q ? 2'd1 : 2'd0) : (rprev_q ? 2'd1 : 2'd2);
  assign rb = 2'd2;

  assign v_ctr = win_pick(win_q, cm, rm);
  assign v_top = win_pick(win_q, cm, rt);
  assign v_bot = win_pick(win_q, cm, rb);
  assign v_lft = win_pick(win_q, cl, rm);
  assign v_rgt = win_pick(win_q, cr, rm);

  // Kernel: four times the center minus the four direct neighbors.
  assign lap_sum  = $signed({2'b00, v_ctr, 2'b00}) - $signed({4'b0, v_top})
                  - $signed({4'b0, v_bot}) - $signed({4'b0, v_lft})
                  - $signed({4'b0, v_rgt});
  assign edge_bit = lap_sum > $signed({edge_threshold_i[10], edge_threshold_i});

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_space) begin
      out_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      is_edge_o     <= edge_bit;
      out_col_o     <= col_prev ? col_q - lapet_pkg::PosW'(1) : col_q;
      out_row_o     <= row_prev ? row_q - lapet_pkg::PosW'(1) : row_q;
      last_of_run_o <= is_last;
      frame_done_o  <= is_last && fend_q;
    end
  end

  // The result index stays within the word's result count.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && (n_q != 3'd0)) |-> ({1'b0, idx_q} < n_q))
    else $error("result index beyond result count");

  // A new word is only taken once the previous one has delivered all its results.
  a_pop_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && job_valid_q) |-> job_done)
    else $error("word replaced before its results were delivered");

endmodule

// ===== rtl/core/laplacian_edge_threshold_top.sv =====
// Top level of the Laplacian edge detector: configuration registers and part wiring.
// Throughput: one pixel per clock unless the front stalls; a pixel yields zero to four
// results, one per clock while the receiver is ready, through the output register.
// Bursts of up to four results per pixel (last row, last column) are absorbed by a
// four-word queue; the front stalls once three words are queued or in flight.
// Reset clears counters, window and control, and loads width 640, height 480,
// threshold 0; the line buffer memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module laplacian_edge_threshold_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [11:0]                 cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  red_i,
  input  logic [7:0]                  green_i,
  input  logic [7:0]                  blue_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        is_edge_o,
  output logic [10:0]                 out_col_o,
  output logic [10:0]                 out_row_o,
  output logic                        last_of_run_o,
  output logic                        frame_done_o
);

  logic [lapet_pkg::SizeW-1:0] frame_width_q, frame_height_q;
  logic [10:0]                 edge_threshold_q;

  logic                        push, pop, q_empty;
  lapet_pkg::item_t            push_item, pop_item;
  logic [lapet_pkg::QCntW-1:0] q_count;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q    <= 12'd640;
      frame_height_q   <= 12'd480;
      edge_threshold_q <= 11'd0;
    end else if (cfg_we_i) begin
      case (lapet_pkg::cfg_idx_e'(cfg_idx_i))
        lapet_pkg::CfgWidth:  frame_width_q    <= cfg_wdata_i;
        lapet_pkg::CfgHeight: frame_height_q   <= cfg_wdata_i;
        lapet_pkg::CfgThresh: edge_threshold_q <= cfg_wdata_i[10:0];
        default: begin
        end
      endcase
    end
  end

  lapet_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .q_count_i      (q_count),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  lapet_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  lapet_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_item_i         (pop_item),
    .q_pop_o          (pop),
    .edge_threshold_i (edge_threshold_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .is_edge_o        (is_edge_o),
    .out_col_o        (out_col_o),
    .out_row_o        (out_row_o),
    .last_of_run_o    (last_of_run_o),
    .frame_done_o     (frame_done_o)
  );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the Laplacian edge detector top level.
`timescale 1ns / 1ps

module testbench;

  localparam int IdleLimit    = 2000;
  localparam int SettleCycles = 8;
  localparam int RandomPixels = 72;
  localparam int MaxReports   = 10;

  // One result word as it leaves the block.
  typedef struct packed {
    logic                       is_edge;
    logic [lapet_pkg::PosW-1:0] col;
    logic [lapet_pkg::PosW-1:0] row;
    logic                       last;
    logic                       done;
  } edge_word_t;

  // Tracks the detector state and holds the edge words still owed by the block.
  class edge_predictor;
    logic [lapet_pkg::SizeW-1:0] width;
    logic [lapet_pkg::SizeW-1:0] height;
    logic [10:0]                 thresh;
    bit [7:0]                    line_above [lapet_pkg::MaxWidth];
    bit [7:0]                    line_cur [lapet_pkg::MaxWidth];
    bit [lapet_pkg::PosW-1:0]    col;
    bit [lapet_pkg::PosW-1:0]    row;
    bit [7:0]                    win [3][3];
    edge_word_t                  expected_edges [$];
    int                          errors;
    int                          reports;

    function new();
      width   = lapet_pkg::SizeW'(640);
      height  = lapet_pkg::SizeW'(480);
      thresh  = '0;
      col     = '0;
      row     = '0;
      errors  = 0;
      reports = 0;
    endfunction

    function void set_reg(lapet_pkg::cfg_idx_e idx, logic [lapet_pkg::SizeW-1:0] val);
      case (idx)
        lapet_pkg::CfgWidth: begin
          width = val;
        end
        lapet_pkg::CfgHeight: begin
          height = val;
        end
        lapet_pkg::CfgThresh: begin
          thresh = val[10:0];
        end
        default: begin
        end
      endcase
    endfunction

    function bit at_frame_start();
      return (col == 0) && (row == 0);
    endfunction

    // Zero acts as one, anything past the limit saturates.
    function int dim_of(logic [lapet_pkg::SizeW-1:0] v, int limit);
      if (v == 0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
    endfunction

    // Window slot of a position relative to the newest column or row.
    function int slot_of(int pos, int cur);
      int s;
      if (pos < 0) pos = 0;
      if (pos > cur) pos = cur;
      s = pos - cur + 2;
      if (s < 0) s = 0;
      return s;
    endfunction

    function int kernel_sum(int i, int j, int c, int r);
      int cl, cm, cr, rt, rm, rb;
      cl = slot_of(i - 1, c);
      cm = slot_of(i, c);
      cr = slot_of(i + 1, c);
      rt = slot_of(j - 1, r);
      rm = slot_of(j, r);
      rb = slot_of(j + 1, r);
      return 4 * int'(win[cm][rm]) - int'(win[cm][rt]) - int'(win[cm][rb])
             - int'(win[cl][rm]) - int'(win[cr][rm]);
    endfunction

    // Advance the state by one accepted pixel and queue the words it releases.
    function void accept_pixel(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
      int         w, h, c, r, thr, acc, nr, nc, a, b;
      int         rows [2];
      int         cols [2];
      bit [7:0]   luma, up, mid;
      bit         last_col, last_row;
      edge_word_t word;
      w   = dim_of(width, int'(lapet_pkg::MaxWidth));
      h   = dim_of(height, int'(lapet_pkg::MaxHeight));
      c   = int'(col);
      r   = int'(row);
      acc = 19595 * int'(rd) + 38470 * int'(gr) + 7471 * int'(bl) + 32768;
      luma = 8'(acc >> 16);
      thr = int'($signed(thresh));
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);

      // Line buffers rotate one row down at this column.
      up  = line_above[c];
      mid = line_cur[c];
      line_above[c] = mid;
      line_cur[c]   = luma;
      for (a = 0; a < 3; a++) begin
        win[0][a] = win[1][a];
        win[1][a] = win[2][a];
      end
      win[2][0] = up;
      win[2][1] = mid;
      win[2][2] = luma;

      // Positions completed by this pixel, row by row.
      nr = 0;
      nc = 0;
      if (r >= 1) begin
        rows[nr] = r - 1;
        nr = nr + 1;
      end
      if (last_row) begin
        rows[nr] = r;
        nr = nr + 1;
      end
      if (c >= 1) begin
        cols[nc] = c - 1;
        nc = nc + 1;
      end
      if (last_col) begin
        cols[nc] = c;
        nc = nc + 1;
      end
      for (a = 0; a < nr; a++) begin
        for (b = 0; b < nc; b++) begin
          word.is_edge = kernel_sum(cols[b], rows[a], c, r) > thr;
          word.col     = lapet_pkg::PosW'(cols[b]);
          word.row     = lapet_pkg::PosW'(rows[a]);
          word.last    = (a == nr - 1) && (b == nc - 1);
          word.done    = word.last && last_col && last_row;
          expected_edges.push_back(word);
        end
      end

      if (last_col) begin
        col = '0;
        row = last_row ? '0 : lapet_pkg::PosW'(r + 1);
      end else begin
        col = lapet_pkg::PosW'(c + 1);
      end
    endfunction

    function void check_edge(edge_word_t got);
      edge_word_t want;
      if (expected_edges.size() == 0) begin
        errors++;
        if (reports < MaxReports) begin
          $display("unexpected word: edge %0b col %0d row %0d last %0b done %0b",
                   got.is_edge, got.col, got.row, got.last, got.done);
        end
        reports++;
        return;
      end
      want = expected_edges.pop_front();
      if (got !== want) begin
        errors++;
        if (reports < MaxReports) begin
          $display("mismatch: expected edge %0b col %0d row %0d last %0b done %0b",
                   want.is_edge, want.col, want.row, want.last, want.done);
          $display("          actual   edge %0b col %0d row %0d last %0b done %0b",
                   got.is_edge, got.col, got.row, got.last, got.done);
        end
        reports++;
      end
    endfunction

    // Words still owed at the end count as failures.
    function void close_out();
      errors += expected_edges.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [11:0]       cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        red_i;
  logic [7:0]        green_i;
  logic [7:0]        blue_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              is_edge_o;
  logic [10:0]       out_col_o;
  logic [10:0]       out_row_o;
  logic              last_of_run_o;
  logic              frame_done_o;

  edge_predictor sb;
  int            burst_left = 0;
  int            idle_cycles = 0;

  laplacian_edge_threshold_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_edge_o     (is_edge_o),
    .out_col_o     (out_col_o),
    .out_row_o     (out_row_o),
    .last_of_run_o (last_of_run_o),
    .frame_done_o  (frame_done_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver switches between stall patterns of random length.
  initial begin : ready_pattern
    int mode, span, k;
    out_ready_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          0: begin
            out_ready_i <= 1'b1;
          end
          1: begin
            out_ready_i <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            out_ready_i <= (k % 3 != 0);
          end
          default: begin
            out_ready_i <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  // Check every accepted word and watch for a stalled run.
  always @(posedge clk_i) begin : monitor
    edge_word_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {is_edge_o, out_col_o, out_row_o, last_of_run_o, frame_done_o};
      sb.check_edge(got);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("[laplacian_edge_threshold_top] ERROR");
      $finish;
    end
  end

  // Offer one pixel, with a random gap at the start of each burst.
  task automatic send_pixel(input logic [7:0] rd, input logic [7:0] gr, input logic [7:0] bl);
    int gap;
    @(negedge clk_i);
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    red_i      <= rd;
    green_i    <= gr;
    blue_i     <= bl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.accept_pixel(rd, gr, bl);
  endtask

  // Stop sending and wait until the block has delivered everything.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.expected_edges.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input lapet_pkg::cfg_idx_e idx, input logic [11:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [7:0] jitter(input logic [7:0] base);
    int v;
    v = int'(base) + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Style 0 is noise, 1 is a flat area with small ripple, 2 is black and white.
  task automatic send_random_pixels(input int count, input int style);
    logic [7:0] base, v;
    int         i;
    base = 8'($urandom_range(0, 255));
    for (i = 0; i < count; i++) begin
      case (style)
        0: begin
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
        1: begin
          send_pixel(jitter(base), jitter(base), jitter(base));
        end
        default: begin
          v = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
          send_pixel(v, v, v);
        end
      endcase
    end
  endtask

  task automatic finish_frame();
    while (!sb.at_frame_start()) begin
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // A 3x3 gray frame: one value in the middle, another all around.
  task automatic send_gray_frame(input logic [7:0] center, input logic [7:0] ring);
    int         i;
    logic [7:0] v;
    for (i = 0; i < 9; i++) begin
      v = (i == 4) ? center : ring;
      send_pixel(v, v, v);
    end
  endtask

  // Widths stay within the columns that both line buffers already hold.
  function automatic logic [11:0] pick_width();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'($urandom_range(13, 24));
      default: return 12'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [11:0] pick_height();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return 12'($urandom_range(9, 40));
      default: return 12'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [11:0] pick_thresh();
    logic [10:0] t;
    case ($urandom_range(0, 9))
      0: t = 11'h3FF;
      1: t = 11'h400;
      2, 3: t = 11'($urandom_range(0, 2047));
      default: t = 11'(int'($urandom_range(0, 120)) - 60);
    endcase
    return {1'($urandom_range(0, 1)), t};
  endfunction

  initial begin : stimulus
    int sent, count;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = lapet_pkg::CfgWidth;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    red_i       = '0;
    green_i     = '0;
    blue_i      = '0;
    rst_ni      = 1'b0;
    sb = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A few primary colors under the reset geometry.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);

    // Shrink the frame mid-row and fill both line buffers across 24 columns.
    settle();
    write_reg(lapet_pkg::CfgWidth, 12'd24);
    write_reg(lapet_pkg::CfgHeight, 12'd2);
    finish_frame();

    // Strongest possible kernel sums against thresholds on either side.
    settle();
    write_reg(lapet_pkg::CfgWidth, 12'd3);
    write_reg(lapet_pkg::CfgHeight, 12'd3);
    write_reg(lapet_pkg::CfgThresh, 12'(1019));
    send_gray_frame(8'd255, 8'd0);
    settle();
    write_reg(lapet_pkg::CfgThresh, 12'(1020));
    send_gray_frame(8'd255, 8'd0);
    settle();
    write_reg(lapet_pkg::CfgThresh, 12'(-1021));
    send_gray_frame(8'd0, 8'd255);
    settle();
    write_reg(lapet_pkg::CfgThresh, 12'(-1020));
    send_gray_frame(8'd0, 8'd255);

    // Zero sizes act as a single pixel frame.
    settle();
    write_reg(lapet_pkg::CfgWidth, 12'd0);
    write_reg(lapet_pkg::CfgHeight, 12'd0);
    write_reg(lapet_pkg::CfgThresh, 12'h7FF);
    send_random_pixels(3, 0);

    // Geometry shrinks past both the current column and row mid-frame.
    settle();
    write_reg(lapet_pkg::CfgWidth, 12'd8);
    write_reg(lapet_pkg::CfgHeight, 12'd6);
    write_reg(lapet_pkg::CfgThresh, 12'(20));
    send_random_pixels(30, 1);
    settle();
    write_reg(lapet_pkg::CfgWidth, 12'd5);
    write_reg(lapet_pkg::CfgHeight, 12'd3);
    send_random_pixels(4, 2);
    finish_frame();

    // A single line under a saturated width, then cut short by a narrow width.
    settle();
    write_reg(lapet_pkg::CfgWidth, 12'hFFF);
    write_reg(lapet_pkg::CfgHeight, 12'd1);
    write_reg(lapet_pkg::CfgThresh, 12'(0));
    send_random_pixels(10, 1);
    settle();
    write_reg(lapet_pkg::CfgWidth, 12'd8);
    finish_frame();

    // A single column under a saturated height, then cut short by a low height.
    settle();
    write_reg(lapet_pkg::CfgWidth, 12'd1);
    write_reg(lapet_pkg::CfgHeight, 12'hFFF);
    write_reg(lapet_pkg::CfgThresh, 12'(-5));
    send_random_pixels(10, 1);
    settle();
    write_reg(lapet_pkg::CfgHeight, 12'd1);
    finish_frame();

    // Random geometry, thresholds and content in short phases.
    settle();
    write_reg(lapet_pkg::CfgWidth, 12'd2048);
    write_reg(lapet_pkg::CfgHeight, 12'd2048);
    sent = 0;
    while (sent < RandomPixels) begin
      if ($urandom_range(0, 3) != 0) begin
        settle();
        if ($urandom_range(0, 2) != 0) write_reg(lapet_pkg::CfgWidth, pick_width());
        if ($urandom_range(0, 2) != 0) write_reg(lapet_pkg::CfgHeight, pick_height());
        if ($urandom_range(0, 2) != 0) write_reg(lapet_pkg::CfgThresh, pick_thresh());
      end
      count = $urandom_range(8, 24);
      send_random_pixels(count, $urandom_range(0, 2));
      sent += count;
    end

    settle();
    sb.close_out();
    if (sb.errors == 0) begin
      $display("[laplacian_edge_threshold_top] OK");
    end else begin
      $display("[laplacian_edge_threshold_top] ERROR");
    end
    $finish;
  end

endmodule
